/* src/mpdc_pkg.sv */
// ----------------------------------------------------------------------------
// mpdc_pkg
// Shared types, widths and arithmetic helpers for the multichannel PID duty
// controller: sequencer states, multiplier request, rounding and saturation.
// ----------------------------------------------------------------------------
package mpdc_pkg;

  // Channel count and field widths
  localparam int unsigned CHANNELS = 10;
  localparam int unsigned ChanW    = 4;   // channel field width
  localparam int unsigned ValW     = 32;  // Q16.16 values
  localparam int unsigned LimW     = 31;  // unsigned bound / band
  localparam int unsigned GainW    = 24;  // Q8.16 gains
  localparam int unsigned IntW     = 40;  // Q24.16 integral
  localparam int unsigned ProdW    = GainW + ValW;  // full product
  localparam int unsigned RndW     = ProdW - 16;    // product scaled by 2^-16
  localparam int unsigned SumW     = IntW + 2;      // P + I + D exact

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_INTEG,
    ST_SUM
  } state_e;

  // Request to the shared multiplier
  typedef struct packed {
    logic                    en;
    logic signed [GainW-1:0] gain;
    logic signed [ValW-1:0]  value;
  } mul_req_t;

  // Scale product by 2^-16, round to nearest, ties toward +inf
  function automatic logic signed [RndW-1:0] round_q16(logic signed [ProdW-1:0] prod);
    logic signed [ProdW-1:0] t;
    t = prod + ProdW'(32768);
    return t[ProdW-1:16];
  endfunction

  // Saturate a 40-bit value to 32 bits signed
  function automatic logic signed [ValW-1:0] sat32_rnd(logic signed [RndW-1:0] x);
    if (x[RndW-1:ValW-1] != {(RndW-ValW+1){x[RndW-1]}}) begin
      return x[RndW-1] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end
    return x[ValW-1:0];
  endfunction

  // Saturate a 33-bit difference to 32 bits signed
  function automatic logic signed [ValW-1:0] sat32_diff(logic signed [ValW:0] x);
    if (x[ValW] != x[ValW-1]) begin
      return x[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end
    return x[ValW-1:0];
  endfunction

  // Saturate a 41-bit sum to 40 bits signed
  function automatic logic signed [IntW-1:0] sat40(logic signed [IntW:0] x);
    if (x[IntW] != x[IntW-1]) begin
      return x[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end
    return x[IntW-1:0];
  endfunction

endpackage

/* src/mpdc_gain_mul.sv */
// ----------------------------------------------------------------------------
// mpdc_gain_mul
// Shared signed gain multiplier: Q8.16 gain times Q16.16 value, product
// registered, then scaled by 2^-16 with round-half-up on the way out.
// ----------------------------------------------------------------------------
module mpdc_gain_mul
  import mpdc_pkg::*;
(
  input  logic                   clk_i,
  input  mul_req_t               req_i,
  output logic signed [RndW-1:0] rnd_o
);

  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;

  // Full-precision product
  assign prod_d = ProdW'(req_i.gain) * ProdW'(req_i.value);

  // Product register, loaded only when a step asks for it
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign rnd_o = round_q16(prod_q);

endmodule

/* src/multichannel_pid_duty_controller_top.sv */
// ----------------------------------------------------------------------------
// multichannel_pid_duty_controller_top
// Ten-channel PID controller with integral reset band and output clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one word per control update. tuser carries the
//   channel, tdata the setpoint, position, bound, three gains and band.
//   Output stream (m_axis_*): one word per input word, in order. tdata is
//   the clamped drive, tuser is set when the clamp was applied.
//   Sequencing: one word at a time. The sequencer runs prepare, three
//   passes through the single shared multiplier, integral update and sum
//   before it takes the next word. A word for an unknown channel skips to
//   the sum step and returns zero drive.
//   tready is high only while the sequencer is idle.
//   Stall: the result sits in an output register; the next word is taken
//   while it waits, and that word's final step holds until it is taken.
//   Reset: all per-channel setpoint, position and integral state clears at
//   once, and no result is pending.
// ----------------------------------------------------------------------------
module multichannel_pid_duty_controller_top
  import mpdc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // target[31:0], measured[63:32], duty_limit[94:64], gain_p[118:95],
  // gain_i[142:119], gain_d[166:143], reset_band[197:167], zero[199:198]
  input  logic [199:0] s_axis_tdata_i,
  // channel[3:0]
  input  logic [3:0]   s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // drive[31:0]
  output logic [31:0]  m_axis_tdata_o,
  // limited[0]
  output logic         m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  // Field offsets in the input word
  localparam int unsigned TgtLo  = 0;
  localparam int unsigned PosLo  = TgtLo + ValW;
  localparam int unsigned LimLo  = PosLo + ValW;
  localparam int unsigned KpLo   = LimLo + LimW;
  localparam int unsigned KiLo   = KpLo + GainW;
  localparam int unsigned KdLo   = KiLo + GainW;
  localparam int unsigned BandLo = KdLo + GainW;

  state_e state_q, state_d;

  // Latched input word
  logic        [ChanW-1:0] ch_q;
  logic                    bad_q;
  logic signed [ValW-1:0]  tgt_q, pos_q;
  logic        [LimW-1:0]  lim_q, band_q;
  logic signed [GainW-1:0] kp_q, ki_q, kd_q;

  // Working registers
  logic signed [ValW-1:0]  err_q, dpos_q, p_q, d_q;
  logic signed [IntW-1:0]  base_q, integ_q;
  logic                    band_hit_q;

  // Per-channel state
  logic signed [ValW-1:0]  last_sp_q   [CHANNELS];
  logic signed [ValW-1:0]  last_meas_q [CHANNELS];
  logic signed [IntW-1:0]  integ_mem_q [CHANNELS];

  // Output register
  logic                    m_valid_q;
  logic signed [ValW-1:0]  drive_q;
  logic                    limited_q;

  logic                    accept;
  logic                    out_load;
  mul_req_t                mul_req;
  logic signed [RndW-1:0]  mul_rnd;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Shared multiplier
  mpdc_gain_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rnd_o (mul_rnd)
  );

  // Sequencer: next state, handshake and multiplier operands
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    mul_req         = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = (32'(s_axis_tuser_i) >= CHANNELS) ? ST_SUM : ST_PREP;
        end
      end
      ST_PREP: state_d = ST_MUL_P;
      ST_MUL_P: begin
        mul_req = '{en: 1'b1, gain: kp_q, value: err_q};
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_req = '{en: 1'b1, gain: kd_q, value: dpos_q};
        state_d = ST_MUL_I;
      end
      ST_MUL_I: begin
        mul_req = '{en: 1'b1, gain: ki_q, value: p_q};
        state_d = ST_INTEG;
      end
      ST_INTEG: state_d = ST_SUM;
      ST_SUM: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Channel state read and prepare-step arithmetic
  logic signed [ValW-1:0] sp_rd, meas_rd, meas_eff;
  logic signed [IntW-1:0] int_rd;
  logic                   sp_chg;
  logic signed [ValW:0]   err_raw, dpos_raw;
  logic        [ValW:0]   err_mag;

  always_comb begin
    sp_rd    = last_sp_q[ch_q];
    meas_rd  = last_meas_q[ch_q];
    int_rd   = integ_mem_q[ch_q];
    sp_chg   = (sp_rd != tgt_q);
    meas_eff = sp_chg ? '0 : meas_rd;
    err_raw  = {tgt_q[ValW-1], tgt_q} - {pos_q[ValW-1], pos_q};
    dpos_raw = {pos_q[ValW-1], pos_q} - {meas_eff[ValW-1], meas_eff};
    err_mag  = err_raw[ValW] ? (~err_raw + 1'b1) : err_raw;
  end

  // Integral update
  logic signed [IntW-1:0] integ_new;
  always_comb begin
    integ_new = sat40({base_q[IntW-1], base_q} + {mul_rnd[RndW-1], mul_rnd});
    if (band_hit_q) begin
      integ_new = '0;
    end
  end

  // Sum and clamp
  logic signed [SumW-1:0] sum, lim_pos, lim_neg;
  logic signed [ValW-1:0] drive_d;
  logic                   limited_d;

  always_comb begin
    sum       = SumW'(p_q) + SumW'(integ_q) + SumW'(d_q);
    lim_pos   = SumW'(lim_q);
    lim_neg   = -lim_pos;
    drive_d   = sum[ValW-1:0];
    limited_d = 1'b0;
    if (sum > lim_pos) begin
      drive_d   = lim_pos[ValW-1:0];
      limited_d = 1'b1;
    end else if (sum < lim_neg) begin
      drive_d   = lim_neg[ValW-1:0];
      limited_d = 1'b1;
    end
    if (bad_q) begin
      drive_d   = '0;
      limited_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Per-channel state, written at the integral step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_sp_q[i]   <= '0;
        last_meas_q[i] <= '0;
        integ_mem_q[i] <= '0;
      end
    end else if (state_q == ST_INTEG) begin
      last_sp_q[ch_q]   <= tgt_q;
      last_meas_q[ch_q] <= pos_q;
      integ_mem_q[ch_q] <= integ_new;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= s_axis_tuser_i;
      bad_q  <= (32'(s_axis_tuser_i) >= CHANNELS);
      tgt_q  <= s_axis_tdata_i[TgtLo +: ValW];
      pos_q  <= s_axis_tdata_i[PosLo +: ValW];
      lim_q  <= s_axis_tdata_i[LimLo +: LimW];
      kp_q   <= s_axis_tdata_i[KpLo +: GainW];
      ki_q   <= s_axis_tdata_i[KiLo +: GainW];
      kd_q   <= s_axis_tdata_i[KdLo +: GainW];
      band_q <= s_axis_tdata_i[BandLo +: LimW];
    end
    if (state_q == ST_PREP) begin
      err_q      <= sat32_diff(err_raw);
      dpos_q     <= sat32_diff(dpos_raw);
      base_q     <= sp_chg ? '0 : int_rd;
      band_hit_q <= (err_mag <= (ValW+1)'(band_q));
    end
    if (state_q == ST_MUL_D) begin
      p_q <= sat32_rnd(mul_rnd);
    end
    if (state_q == ST_MUL_I) begin
      d_q <= sat32_rnd(mul_rnd);
    end
    if (state_q == ST_INTEG) begin
      integ_q <= integ_new;
    end
    if (out_load) begin
      drive_q   <= drive_d;
      limited_q <= limited_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = drive_q;
  assign m_axis_tuser_o  = limited_q;

endmodule

/* src/mpdc_checker.sv */
// ----------------------------------------------------------------------------
// mpdc_checker
// Port-level checks for the PID duty controller, bound to the top level.
// ----------------------------------------------------------------------------
module mpdc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [31:0]  m_axis_tdata_o,
  input logic         m_axis_tuser_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // One word in flight: ready drops right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // No result appears in the cycle right after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result shown too early");

  // Nothing pending when reset is released
  a_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid out of reset");

endmodule

bind multichannel_pid_duty_controller_top mpdc_checker u_mpdc_checker (.*);

/* tb/tb_multichannel_pid_duty_controller_top.sv */
// ----------------------------------------------------------------------------
// tb_multichannel_pid_duty_controller_top
// Self-checking bench for the multichannel PID duty controller. A queue of
// control words is built up front: a directed set (extremes, rounding ties,
// unknown channels, setpoint change, integral saturation, zero bound, band
// clear), then random per-channel control sequences mixed with noise. The
// driver sends them in bursts with random gaps and predicts each accepted
// word with a Q16.16 model of the controller; the monitor stalls on its own
// pattern and checks every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_multichannel_pid_duty_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpdc_pkg::*;

  localparam int unsigned NumRandom  = 1900;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned TailCycles = 20;

  localparam longint MaxQ32 = 64'sd2147483647;
  localparam longint MinQ32 = -64'sd2147483648;
  localparam longint MaxQ40 = 64'sd549755813887;
  localparam longint MinQ40 = -64'sd549755813888;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_FULL,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  // One control update; hold marks a pause until all results are back
  typedef struct {
    bit                       hold;
    logic [ChanW-1:0]         chan;
    logic signed [ValW-1:0]   tgt;
    logic signed [ValW-1:0]   pos;
    logic [LimW-1:0]          lim;
    logic signed [GainW-1:0]  kp;
    logic signed [GainW-1:0]  ki;
    logic signed [GainW-1:0]  kd;
    logic [LimW-1:0]          band;
  } ctl_word_t;

  typedef struct packed {
    logic [ValW-1:0] drive;
    logic            limited;
  } drive_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [199:0] s_axis_tdata_i = '0;
  logic [3:0]   s_axis_tuser_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [31:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;

  multichannel_pid_duty_controller_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  always #5 clk_i = ~clk_i;

  ctl_word_t  ctl_q[$];     // words still to send
  drive_res_t drive_q[$];   // predicted results in order
  int unsigned err_cnt = 0;

  // Per-channel controller state of the predictor
  longint chan_setpt[CHANNELS];
  longint chan_pos[CHANNELS];
  longint chan_integ[CHANNELS];

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      chan_setpt[i] = 0;
      chan_pos[i]   = 0;
      chan_integ[i] = 0;
    end
  end

  function automatic longint sat_to(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Q8.16 gain times Q16.16 value, rounded half up back to Q16.16
  function automatic longint scale_gain(longint g, longint v);
    return (g * v + 64'sd32768) >>> 16;
  endfunction

  // Run one control step on the predictor state
  function automatic drive_res_t predict_drive(ctl_word_t w);
    drive_res_t r;
    int unsigned ch;
    longint tgt, pos, lim, band, err_raw, err, p, ip, d, sum, mag, drv;
    r.drive   = '0;
    r.limited = 1'b0;
    ch = 32'(w.chan);
    if (ch >= CHANNELS) return r;
    tgt  = longint'(w.tgt);
    pos  = longint'(w.pos);
    lim  = longint'(w.lim);
    band = longint'(w.band);
    // new setpoint restarts the loop
    if (chan_setpt[ch] != tgt) begin
      chan_integ[ch] = 0;
      chan_pos[ch]   = 0;
    end
    err_raw = tgt - pos;
    err = sat_to(err_raw, MinQ32, MaxQ32);
    p   = sat_to(scale_gain(longint'(w.kp), err), MinQ32, MaxQ32);
    ip  = sat_to(scale_gain(longint'(w.ki), p), MinQ40, MaxQ40);
    chan_integ[ch] = sat_to(chan_integ[ch] + ip, MinQ40, MaxQ40);
    d = sat_to(scale_gain(longint'(w.kd), sat_to(pos - chan_pos[ch], MinQ32, MaxQ32)),
               MinQ32, MaxQ32);
    mag = (err_raw < 0) ? -err_raw : err_raw;
    if (mag <= band) chan_integ[ch] = 0;
    sum = p + chan_integ[ch] + d;
    drv = sum;
    if (drv > lim) begin
      drv = lim;
      r.limited = 1'b1;
    end
    if (drv < -lim) begin
      drv = -lim;
      r.limited = 1'b1;
    end
    chan_pos[ch]   = pos;
    chan_setpt[ch] = tgt;
    r.drive = drv[31:0];
    return r;
  endfunction

  function automatic ctl_word_t mk_word(logic [ChanW-1:0] chan, logic signed [ValW-1:0] tgt,
                                        logic signed [ValW-1:0] pos, logic [LimW-1:0] lim,
                                        logic signed [GainW-1:0] kp,
                                        logic signed [GainW-1:0] ki,
                                        logic signed [GainW-1:0] kd, logic [LimW-1:0] band);
    ctl_word_t w;
    w.hold = 1'b0;
    w.chan = chan;
    w.tgt  = tgt;
    w.pos  = pos;
    w.lim  = lim;
    w.kp   = kp;
    w.ki   = ki;
    w.kd   = kd;
    w.band = band;
    return w;
  endfunction

  // Random value generators, biased toward extremes and small magnitudes
  function automatic logic signed [ValW-1:0] rnd_q16();
    int v;
    v = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return v;
    endcase
  endfunction

  function automatic logic signed [GainW-1:0] rnd_gain();
    int v;
    v = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    case ($urandom_range(0, 9))
      0:       return 24'sh7f_ffff;
      1:       return 24'sh80_0000;
      2:       return '0;
      3, 4:    return GainW'($urandom);
      default: return GainW'(v);
    endcase
  endfunction

  function automatic logic [LimW-1:0] rnd_bound();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 31'h7fff_ffff;
      2, 3, 4: return LimW'($urandom);
      default: return LimW'($urandom_range(0, 32'h0080_0000));
    endcase
  endfunction

  function automatic logic [LimW-1:0] rnd_band();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return 31'h7fff_ffff;
      3, 4:    return LimW'($urandom);
      default: return LimW'($urandom_range(0, 32'h0002_0000));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts with random gaps, prediction at each accepted word
  // --------------------------------------------------------------------------
  ctl_word_t   cur_word;
  ctl_word_t   nxt_word;
  bit          nxt_valid;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        drive_q.push_back(predict_drive(cur_word));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (ctl_q.size() > 0) begin
          if (ctl_q[0].hold) begin
            // let the pipeline drain completely
            if (drive_q.size() == 0) void'(ctl_q.pop_front());
          end else begin
            nxt_word  = ctl_q.pop_front();
            cur_word  = nxt_word;
            nxt_valid = 1'b1;
            s_axis_tdata_i <= {2'b00, nxt_word.band, nxt_word.kd, nxt_word.ki, nxt_word.kp,
                               nxt_word.lim, nxt_word.pos, nxt_word.tgt};
            s_axis_tuser_i <= nxt_word.chan;
            burst_left--;
            if (burst_left == 0) begin
              if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(50, 200);
                gap_left   = 0;
              end else begin
                burst_left = $urandom_range(1, 12);
                gap_left   = $urandom_range(0, 25);
              end
            end
          end
        end
        s_axis_tvalid_i <= nxt_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: own stall pattern, in-order compare
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode;
  int unsigned rx_left;
  int unsigned rx_cyc;
  drive_res_t  exp_res;
  logic        rx_ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rx_mode = RX_FULL;
      rx_left = 0;
      rx_cyc  = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (drive_q.size() == 0) begin
          $error("unexpected result word: drive %h, limited %b",
                 m_axis_tdata_o, m_axis_tuser_o);
          err_cnt++;
        end else begin
          exp_res = drive_q.pop_front();
          if (m_axis_tdata_o !== exp_res.drive) begin
            $error("drive mismatch: expected %h, actual %h", exp_res.drive, m_axis_tdata_o);
            err_cnt++;
          end
          if (m_axis_tuser_o !== exp_res.limited) begin
            $error("limited mismatch: expected %b, actual %b",
                   exp_res.limited, m_axis_tuser_o);
            err_cnt++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(50, 400);
      end else begin
        rx_left--;
      end
      rx_cyc++;
      case (rx_mode)
        RX_FULL:     rx_ready = 1'b1;
        RX_MOSTLY:   rx_ready = ($urandom_range(0, 3) != 0);
        RX_SPARSE:   rx_ready = ($urandom_range(0, 3) == 0);
        default:     rx_ready = ((rx_cyc % 11) < 4);
      endcase
      m_axis_tready_i <= rx_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any accepted word on either side
  // --------------------------------------------------------------------------
  int unsigned idle_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
      if (idle_cnt >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  ctl_word_t          hold_word;
  int unsigned        n_items;
  int unsigned        n_steps;
  logic [ChanW-1:0]   s_chan;
  logic signed [31:0] s_tgt, s_pos;
  logic signed [23:0] s_kp, s_ki, s_kd;
  logic [30:0]        s_lim, s_band;

  initial begin
    hold_word = mk_word('0, '0, '0, '0, '0, '0, '0, '0);
    hold_word.hold = 1'b1;

    // all zero
    ctl_q.push_back(mk_word(4'd0, '0, '0, '0, '0, '0, '0, '0));
    // saturated error both ways, extreme gains
    ctl_q.push_back(mk_word(4'd0, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff,
                            24'sh7f_ffff, 24'sh80_0000, 24'sh7f_ffff, '0));
    ctl_q.push_back(mk_word(4'd0, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff,
                            24'sh80_0000, 24'sh7f_ffff, 24'sh80_0000, '0));
    // unknown channels
    ctl_q.push_back(mk_word(4'd10, 32'sh0001_0000, '0, 31'h7fff_ffff,
                            24'sh01_0000, 24'sh01_0000, 24'sh01_0000, '0));
    ctl_q.push_back(mk_word(4'd15, $urandom, $urandom, LimW'($urandom), GainW'($urandom),
                            GainW'($urandom), GainW'($urandom), LimW'($urandom)));
    // rounding ties, positive and negative
    ctl_q.push_back(mk_word(4'd5, 32'sd32768, '0, 31'h7fff_ffff, 24'sd1, '0, '0, '0));
    ctl_q.push_back(mk_word(4'd5, -32'sd32768, '0, 31'h7fff_ffff, 24'sd1, '0, '0, '0));
    // zero bound: nonzero and zero sum
    ctl_q.push_back(mk_word(4'd6, 32'sh0003_0000, '0, '0, 24'sh01_0000, '0, '0, '0));
    ctl_q.push_back(mk_word(4'd7, '0, '0, '0, 24'sh01_0000, '0, '0, '0));
    // error beyond even the widest band: the integral is kept
    ctl_q.push_back(mk_word(4'd8, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff,
                            24'sh01_0000, 24'sh7f_ffff, '0, 31'h7fff_ffff));
    // same setpoint twice, then a new one
    ctl_q.push_back(mk_word(4'd1, 32'sh0010_0000, 32'sh0008_0000, 31'h0100_0000,
                            24'sh02_0000, 24'sh00_8000, 24'sh00_4000, 31'h0000_1000));
    ctl_q.push_back(mk_word(4'd1, 32'sh0010_0000, 32'sh000c_0000, 31'h0100_0000,
                            24'sh02_0000, 24'sh00_8000, 24'sh00_4000, 31'h0000_1000));
    ctl_q.push_back(mk_word(4'd1, 32'sh0011_0000, 32'sh000e_0000, 31'h0100_0000,
                            24'sh02_0000, 24'sh00_8000, 24'sh00_4000, 31'h0000_1000));
    // integral runs into both 40-bit rails
    repeat (5) ctl_q.push_back(mk_word(4'd2, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff,
                                       24'sh7f_ffff, 24'sh7f_ffff, '0, '0));
    repeat (4) ctl_q.push_back(mk_word(4'd4, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff,
                                       24'sh7f_ffff, 24'sh7f_ffff, '0, '0));
    // position jump saturates the derivative input
    ctl_q.push_back(mk_word(4'd3, 32'sh0000_1000, 32'sh8000_0000, 31'h7fff_ffff,
                            '0, '0, 24'sh7f_ffff, '0));
    ctl_q.push_back(mk_word(4'd3, 32'sh0000_1000, 32'sh7fff_ffff, 31'h7fff_ffff,
                            '0, '0, 24'sh80_0000, '0));
    ctl_q.push_back(hold_word);

    // random control sequences with some noise
    n_items = 0;
    while (n_items < NumRandom) begin
      if (n_items > NumRandom / 2 && n_items < NumRandom / 2 + 12) begin
        ctl_q.push_back(hold_word);
      end
      if ($urandom_range(0, 6) == 0) begin
        ctl_q.push_back(mk_word(ChanW'($urandom), $urandom, $urandom, LimW'($urandom),
                                GainW'($urandom), GainW'($urandom), GainW'($urandom),
                                LimW'($urandom)));
        n_items++;
      end else begin
        s_chan = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, CHANNELS - 1));
        s_tgt  = rnd_q16();
        s_pos  = ($urandom_range(0, 2) == 0) ? rnd_q16()
               : s_tgt + (int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        s_kp   = rnd_gain();
        s_ki   = rnd_gain();
        s_kd   = rnd_gain();
        s_lim  = rnd_bound();
        s_band = rnd_band();
        n_steps = $urandom_range(1, 10);
        repeat (n_steps) begin
          ctl_q.push_back(mk_word(s_chan, s_tgt, s_pos, s_lim, s_kp, s_ki, s_kd, s_band));
          n_items++;
          // plant moves a little in either direction
          s_pos = s_pos + (int'($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000);
          if ($urandom_range(0, 9) == 0) s_tgt = rnd_q16();
          if ($urandom_range(0, 9) == 0) s_band = rnd_band();
        end
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ctl_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (err_cnt == 0 && drive_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mpdc_pkg.sv
src/mpdc_gain_mul.sv
src/multichannel_pid_duty_controller_top.sv
src/mpdc_checker.sv
tb/tb_multichannel_pid_duty_controller_top.sv
